FILE: rtl/core/ddpi_pkg.sv
// ----------------------------------------------------------------------------
// ddpi_pkg
// Types, constants and tables shared by the pose integrator modules.
// ----------------------------------------------------------------------------
package ddpi_pkg;

  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned DivW           = 40;
  localparam int unsigned DsrW           = 17;

  localparam logic [29:0]        InvTwoPi    = 30'd683565276;
  localparam logic signed [33:0] CordicStart = 34'sd652032874;

  typedef enum logic [2:0] {
    CFG_RADIUS = 3'd0,
    CFG_TRACK  = 3'd1,
    CFG_STEP   = 3'd2,
    CFG_LIMIT  = 3'd3,
    CFG_READY  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] wheel_radius;
    logic [15:0] half_track;
    logic [15:0] time_step;
    logic [14:0] wheel_limit;
    logic        wheels_ready;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_MUL_LL, OP_DIV_L, OP_SET_L, OP_MUL_LR, OP_DIV_R, OP_SET_R,
    OP_MUL_DR, OP_DIV_W, OP_SET_W, OP_MUL_T0, OP_MUL_T1, OP_T_SUM, OP_MUL_H0,
    OP_MUL_H1, OP_HEAD, OP_ROT_S, OP_MUL_D1, OP_SET_DM, OP_TRIG, OP_MUL_X0,
    OP_MUL_X1, OP_POSE_X, OP_MUL_Y0, OP_MUL_Y1, OP_POSE_Y, OP_OUTPUT
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHECK, ST_MUL_LL, ST_DIV_L, ST_WAIT_L, ST_SET_L, ST_MUL_LR,
    ST_DIV_R, ST_WAIT_R, ST_SET_R, ST_MUL_DR, ST_DIV_W, ST_WAIT_W, ST_SET_W,
    ST_MUL_T0, ST_MUL_T1, ST_T_SUM, ST_MUL_H0, ST_MUL_H1, ST_HEAD, ST_ROT_S,
    ST_MUL_D1, ST_SET_DM, ST_WAIT_C, ST_TRIG, ST_MUL_X0, ST_MUL_X1, ST_POSE_X,
    ST_MUL_Y0, ST_MUL_Y1, ST_POSE_Y, ST_DONE
  } state_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic need_limit;
    logic wheels_ready;
    logic div_done;
    logic rot_done;
  } stat_t;

  function automatic logic [29:0] atan_angle(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'h20000000;
      5'd1:  v = 30'h12E4051E;
      5'd2:  v = 30'h09FB385B;
      5'd3:  v = 30'h051111D4;
      5'd4:  v = 30'h028B0D43;
      5'd5:  v = 30'h0145D7E1;
      5'd6:  v = 30'h00A2F61E;
      5'd7:  v = 30'h00517C55;
      5'd8:  v = 30'h0028BE53;
      5'd9:  v = 30'h00145F2F;
      5'd10: v = 30'h000A2F98;
      5'd11: v = 30'h000517CC;
      5'd12: v = 30'h00028BE6;
      5'd13: v = 30'h000145F3;
      5'd14: v = 30'h0000A2FA;
      5'd15: v = 30'h0000517D;
      5'd16: v = 30'h000028BE;
      5'd17: v = 30'h0000145F;
      5'd18: v = 30'h00000A30;
      5'd19: v = 30'h00000518;
      5'd20: v = 30'h0000028C;
      5'd21: v = 30'h00000146;
      5'd22: v = 30'h000000A3;
      5'd23: v = 30'h00000051;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/ddpi_if.sv
// ----------------------------------------------------------------------------
// ddpi_if
// Channel interfaces: wheel speed input, pose output, register write.
// ----------------------------------------------------------------------------
interface ddpi_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_speed;
  logic signed [15:0] right_speed;
  modport source (output valid, left_speed, right_speed, input ready);
  modport sink   (input valid, left_speed, right_speed, output ready);
endinterface

interface ddpi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic        [15:0] heading_angle;
  logic               was_limited;
  logic               not_ready;
  modport source (output valid, pos_x, pos_y, heading_angle, was_limited, not_ready,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, heading_angle, was_limited, not_ready,
                  output ready);
endinterface

interface ddpi_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/ddpi_div.sv
// ----------------------------------------------------------------------------
// ddpi_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ddpi_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ddpi_pkg::DivW-1:0]  dividend_i,
  input  logic [ddpi_pkg::DsrW-1:0]  divisor_i,
  output logic [ddpi_pkg::DivW-1:0]  quotient_o,
  output logic                       done_o
);
  import ddpi_pkg::*;

  localparam int unsigned CntW = $clog2(DivW);
  localparam logic [CntW-1:0] LastCnt = CntW'(DivW - 1);

  logic [DivW-1:0] quo_q, quo_d;
  logic [DsrW-1:0] rem_q, rem_d, dsr_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [DsrW:0]   rem_sh;
  logic            ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[DivW-1]};
    ge     = rem_sh >= {1'b0, dsr_q};
    rem_d  = ge ? DsrW'(rem_sh - {1'b0, dsr_q}) : DsrW'(rem_sh);
    quo_d  = {quo_q[DivW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LastCnt) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

FILE: rtl/core/ddpi_cordic.sv
// ----------------------------------------------------------------------------
// ddpi_cordic
// Iterative rotation CORDIC giving cosine and sine of a binary angle.
// ----------------------------------------------------------------------------
module ddpi_cordic #(
  parameter int unsigned CORDIC_STEPS = ddpi_pkg::CordicStepsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [15:0]        angle_i,
  output logic signed [33:0] cos_o,
  output logic signed [33:0] sin_o,
  output logic               done_o
);
  import ddpi_pkg::*;

  localparam int unsigned IterW = $clog2(CORDIC_STEPS);
  localparam logic [IterW-1:0] LastIter = IterW'(CORDIC_STEPS - 1);

  logic signed [33:0] x_q, y_q, z_q, x_n, y_n, z_n, xs, ys, at;
  logic [IterW-1:0]   iter_q;
  logic               busy_q, done_q, flip_q, flip;
  logic [15:0]        ang_adj;

  always_comb begin
    flip    = angle_i[15] ^ angle_i[14];
    ang_adj = angle_i ^ {flip, 15'b0};
    xs      = x_q >>> iter_q;
    ys      = y_q >>> iter_q;
    at      = {4'b0, atan_angle(5'(iter_q))};
    if (!z_q[33]) begin
      x_n = x_q - ys;
      y_n = y_q + xs;
      z_n = z_q - at;
    end else begin
      x_n = x_q + ys;
      y_n = y_q - xs;
      z_n = z_q + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      iter_q <= '0;
    end else if (busy_q) begin
      iter_q <= iter_q + 1'b1;
      if (iter_q == LastIter) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= CordicStart;
      y_q    <= '0;
      z_q    <= {{2{ang_adj[15]}}, ang_adj, 16'b0};
      flip_q <= flip;
    end else if (busy_q) begin
      z_q <= z_n;
      if (iter_q == LastIter && flip_q) begin
        x_q <= -x_n;
        y_q <= -y_n;
      end else begin
        x_q <= x_n;
        y_q <= y_n;
      end
    end
  end

  assign cos_o  = x_q;
  assign sin_o  = y_q;
  assign done_o = done_q;

endmodule

FILE: rtl/core/ddpi_datapath.sv
// ----------------------------------------------------------------------------
// ddpi_datapath
// Pose state, shared multiplier, divider and CORDIC driven by op commands.
// ----------------------------------------------------------------------------
module ddpi_datapath #(
  parameter int unsigned CORDIC_STEPS = ddpi_pkg::CordicStepsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ddpi_pkg::cmd_t     cmd_i,
  output ddpi_pkg::stat_t    stat_o,
  input  ddpi_pkg::cfg_t     cfg_i,
  input  logic signed [15:0] left_speed_i,
  input  logic signed [15:0] right_speed_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic [15:0]        heading_angle_o,
  output logic               was_limited_o,
  output logic               not_ready_o
);
  import ddpi_pkg::*;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647)       r = 32'sh7FFFFFFF;
    else if (v < -36'sd2147483648) r = 32'sh80000000;
    else                           r = v[31:0];
    return r;
  endfunction

  logic signed [16:0] ls_q, rs_q;
  logic [15:0]        m_q;
  logic               limited_q, negd_q, negs_q, cxn_q, cyn_q;
  logic [16:0]        mags_q;
  logic [64:0]        prod_q, acc_q;
  logic [39:0]        w_q;
  logic [55:0]        t_q;
  logic [48:0]        dm_q;
  logic [31:0]        cx_q, cy_q;
  logic signed [31:0] pose_x_q, pose_y_q;
  logic [15:0]        heading_q;

  logic [14:0]        lim;
  logic [16:0]        b2;
  logic [15:0]        al, ar, mx, magd;
  logic signed [17:0] d18, s18;
  logic [16:0]        mags;
  logic [32:0]        mul_a;
  logic [31:0]        mul_b;
  logic               mul_en;
  logic               div_start, rot_start;
  logic [DivW-1:0]    dividend, quotient;
  logic [DsrW-1:0]    divisor;
  logic               div_done, rot_done;
  logic signed [33:0] cos_v, sin_v;
  logic [31:0]        hsum;
  logic [57:0]        psum;
  logic [34:0]        pmag;
  logic               pneg;
  logic signed [35:0] pdelta, pnew;
  logic signed [31:0] pose_sel;

  always_comb begin
    lim  = (cfg_i.wheel_limit == '0) ? 15'd1 : cfg_i.wheel_limit;
    b2   = {((cfg_i.half_track == '0) ? 16'd1 : cfg_i.half_track), 1'b0};
    al   = 16'(ls_q[16] ? -ls_q : ls_q);
    ar   = 16'(rs_q[16] ? -rs_q : rs_q);
    mx   = (al > ar) ? al : ar;
    d18  = {ls_q[16], ls_q} - {rs_q[16], rs_q};
    s18  = {ls_q[16], ls_q} + {rs_q[16], rs_q};
    magd = 16'(d18[17] ? -d18 : d18);
    mags = 17'(s18[17] ? -s18 : s18);
    hsum = acc_q[31:0] + prod_q[63:32];
    psum = 58'(acc_q[56:0]) + 58'(prod_q[63:24]);
    pmag = psum[57:23];
    pose_sel = (cmd_i.op == OP_POSE_Y) ? pose_y_q : pose_x_q;
    pneg = negs_q ^ ((cmd_i.op == OP_POSE_Y) ? cyn_q : cxn_q);
    pdelta = pneg ? -$signed({1'b0, pmag}) : $signed({1'b0, pmag});
    pnew = {{4{pose_sel[31]}}, pose_sel} + pdelta;
  end

  always_comb begin
    mul_en    = 1'b1;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    rot_start = 1'b0;
    dividend  = 40'(prod_q[31:0]);
    divisor   = {1'b0, m_q};
    case (cmd_i.op)
      OP_MUL_LL: begin mul_a = 33'(al); mul_b = 32'(lim); end
      OP_MUL_LR: begin mul_a = 33'(ar); mul_b = 32'(lim); end
      OP_DIV_L, OP_DIV_R: div_start = 1'b1;
      OP_MUL_DR: begin mul_a = 33'(magd); mul_b = 32'(cfg_i.wheel_radius); end
      OP_DIV_W: begin
        div_start = 1'b1;
        dividend  = {prod_q[31:0], 8'h00};
        divisor   = b2;
      end
      OP_MUL_T0: begin mul_a = 33'(w_q[31:0]); mul_b = 32'(cfg_i.time_step); end
      OP_MUL_T1: begin mul_a = 33'(w_q[39:32]); mul_b = 32'(cfg_i.time_step); end
      OP_MUL_H0: begin mul_a = 33'(t_q[55:32]); mul_b = 32'(InvTwoPi); end
      OP_MUL_H1: begin mul_a = 33'(t_q[31:0]); mul_b = 32'(InvTwoPi); end
      OP_ROT_S: begin
        rot_start = 1'b1;
        mul_a     = 33'(mags_q);
        mul_b     = 32'(cfg_i.wheel_radius);
      end
      OP_MUL_D1: begin mul_a = prod_q[32:0]; mul_b = 32'(cfg_i.time_step); end
      OP_MUL_X0: begin mul_a = 33'(dm_q[48:24]); mul_b = cx_q; end
      OP_MUL_X1: begin mul_a = 33'(dm_q[23:0]); mul_b = cx_q; end
      OP_MUL_Y0: begin mul_a = 33'(dm_q[48:24]); mul_b = cy_q; end
      OP_MUL_Y1: begin mul_a = 33'(dm_q[23:0]); mul_b = cy_q; end
      default: mul_en = 1'b0;
    endcase
  end

  ddpi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  ddpi_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rot_start),
    .angle_i (heading_q),
    .cos_o   (cos_v),
    .sin_o   (sin_v),
    .done_o  (rot_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose_x_q  <= '0;
      pose_y_q  <= '0;
      heading_q <= '0;
    end else begin
      case (cmd_i.op)
        OP_HEAD:   heading_q <= negd_q ? heading_q - hsum[31:16]
                                       : heading_q + hsum[31:16];
        OP_POSE_X: pose_x_q <= sat32(pnew);
        OP_POSE_Y: pose_y_q <= sat32(pnew);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) prod_q <= {32'b0, mul_a} * {33'b0, mul_b};
    case (cmd_i.op)
      OP_LOAD: begin
        ls_q      <= {left_speed_i[15], left_speed_i};
        rs_q      <= {right_speed_i[15], right_speed_i};
        limited_q <= 1'b0;
      end
      OP_MUL_LL: m_q <= mx;
      OP_SET_L: begin
        ls_q      <= ls_q[16] ? -$signed(quotient[16:0]) : $signed(quotient[16:0]);
        limited_q <= 1'b1;
      end
      OP_SET_R: rs_q <= rs_q[16] ? -$signed(quotient[16:0]) : $signed(quotient[16:0]);
      OP_MUL_DR: begin
        mags_q <= mags;
        negd_q <= d18[17];
        negs_q <= s18[17];
      end
      OP_SET_W:  w_q <= quotient;
      OP_MUL_T1, OP_MUL_H1, OP_MUL_X1, OP_MUL_Y1: acc_q <= prod_q;
      OP_T_SUM:  t_q <= 56'(acc_q[47:0]) + {prod_q[23:0], 32'b0};
      OP_SET_DM: dm_q <= prod_q[48:0];
      OP_TRIG: begin
        cx_q  <= 32'(cos_v[33] ? -cos_v : cos_v);
        cy_q  <= 32'(sin_v[33] ? -sin_v : sin_v);
        cxn_q <= cos_v[33];
        cyn_q <= sin_v[33];
      end
      OP_OUTPUT: begin
        pos_x_o         <= pose_x_q;
        pos_y_o         <= pose_y_q;
        heading_angle_o <= heading_q;
        was_limited_o   <= limited_q;
        not_ready_o     <= !cfg_i.wheels_ready;
      end
      default: ;
    endcase
  end

  assign stat_o.need_limit   = (al >= {1'b0, lim}) || (ar >= {1'b0, lim});
  assign stat_o.wheels_ready = cfg_i.wheels_ready;
  assign stat_o.div_done     = div_done;
  assign stat_o.rot_done     = rot_done;

endmodule

FILE: rtl/core/ddpi_ctrl.sv
// ----------------------------------------------------------------------------
// ddpi_ctrl
// Step sequencer: one op per cycle outside wait states; runs the handshakes.
// ----------------------------------------------------------------------------
module ddpi_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  ddpi_pkg::stat_t stat_i,
  output ddpi_pkg::cmd_t  cmd_o
);
  import ddpi_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_CHECK;
      ST_CHECK: begin
        if (!stat_i.wheels_ready)   state_d = ST_DONE;
        else if (stat_i.need_limit) state_d = ST_MUL_LL;
        else                        state_d = ST_MUL_DR;
      end
      ST_MUL_LL: state_d = ST_DIV_L;
      ST_DIV_L:  state_d = ST_WAIT_L;
      ST_WAIT_L: if (stat_i.div_done) state_d = ST_SET_L;
      ST_SET_L:  state_d = ST_MUL_LR;
      ST_MUL_LR: state_d = ST_DIV_R;
      ST_DIV_R:  state_d = ST_WAIT_R;
      ST_WAIT_R: if (stat_i.div_done) state_d = ST_SET_R;
      ST_SET_R:  state_d = ST_MUL_DR;
      ST_MUL_DR: state_d = ST_DIV_W;
      ST_DIV_W:  state_d = ST_WAIT_W;
      ST_WAIT_W: if (stat_i.div_done) state_d = ST_SET_W;
      ST_SET_W:  state_d = ST_MUL_T0;
      ST_MUL_T0: state_d = ST_MUL_T1;
      ST_MUL_T1: state_d = ST_T_SUM;
      ST_T_SUM:  state_d = ST_MUL_H0;
      ST_MUL_H0: state_d = ST_MUL_H1;
      ST_MUL_H1: state_d = ST_HEAD;
      ST_HEAD:   state_d = ST_ROT_S;
      ST_ROT_S:  state_d = ST_MUL_D1;
      ST_MUL_D1: state_d = ST_SET_DM;
      ST_SET_DM: state_d = ST_WAIT_C;
      ST_WAIT_C: if (stat_i.rot_done) state_d = ST_TRIG;
      ST_TRIG:   state_d = ST_MUL_X0;
      ST_MUL_X0: state_d = ST_MUL_X1;
      ST_MUL_X1: state_d = ST_POSE_X;
      ST_POSE_X: state_d = ST_MUL_Y0;
      ST_MUL_Y0: state_d = ST_MUL_Y1;
      ST_MUL_Y1: state_d = ST_POSE_Y;
      ST_POSE_Y: state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NONE;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      ST_MUL_LL: cmd_o.op = OP_MUL_LL;
      ST_DIV_L:  cmd_o.op = OP_DIV_L;
      ST_SET_L:  cmd_o.op = OP_SET_L;
      ST_MUL_LR: cmd_o.op = OP_MUL_LR;
      ST_DIV_R:  cmd_o.op = OP_DIV_R;
      ST_SET_R:  cmd_o.op = OP_SET_R;
      ST_MUL_DR: cmd_o.op = OP_MUL_DR;
      ST_DIV_W:  cmd_o.op = OP_DIV_W;
      ST_SET_W:  cmd_o.op = OP_SET_W;
      ST_MUL_T0: cmd_o.op = OP_MUL_T0;
      ST_MUL_T1: cmd_o.op = OP_MUL_T1;
      ST_T_SUM:  cmd_o.op = OP_T_SUM;
      ST_MUL_H0: cmd_o.op = OP_MUL_H0;
      ST_MUL_H1: cmd_o.op = OP_MUL_H1;
      ST_HEAD:   cmd_o.op = OP_HEAD;
      ST_ROT_S:  cmd_o.op = OP_ROT_S;
      ST_MUL_D1: cmd_o.op = OP_MUL_D1;
      ST_SET_DM: cmd_o.op = OP_SET_DM;
      ST_TRIG:   cmd_o.op = OP_TRIG;
      ST_MUL_X0: cmd_o.op = OP_MUL_X0;
      ST_MUL_X1: cmd_o.op = OP_MUL_X1;
      ST_POSE_X: cmd_o.op = OP_POSE_X;
      ST_MUL_Y0: cmd_o.op = OP_MUL_Y0;
      ST_MUL_Y1: cmd_o.op = OP_MUL_Y1;
      ST_POSE_Y: cmd_o.op = OP_POSE_Y;
      ST_DONE:   if (out_free) cmd_o.op = OP_OUTPUT;
      default:   cmd_o.op = OP_NONE;
    endcase
    out_valid_d = (out_valid_q && !out_ready_i) || (cmd_o.op == OP_OUTPUT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/core/diff_drive_pose_integrator_unit.sv
// ----------------------------------------------------------------------------
// diff_drive_pose_integrator_unit
// Differential drive odometry: wheel speeds in, integrated pose out.
// ----------------------------------------------------------------------------
// Timing is set by the bit-serial divider (one run, or three when the speeds
// are limited) and the CORDIC; with wheels not ready both are skipped.
// One item is in work at a time; the next can be taken once the result is in
// the output register. Reset clears pose and heading to zero, loads the
// register defaults; no clearing pass.
module diff_drive_pose_integrator_unit #(
  parameter int unsigned CORDIC_STEPS = ddpi_pkg::CordicStepsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ddpi_cfg_if.sink   cfg_i,
  ddpi_in_if.sink    in_i,
  ddpi_out_if.source out_o
);
  import ddpi_pkg::*;

  cfg_t  cfg_q;
  cmd_t  cmd;
  stat_t stat;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wheel_radius <= 16'd18;
      cfg_q.half_track   <= 16'd77;
      cfg_q.time_step    <= 16'd6554;
      cfg_q.wheel_limit  <= 15'd2560;
      cfg_q.wheels_ready <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_RADIUS: cfg_q.wheel_radius <= cfg_i.data;
        CFG_TRACK:  cfg_q.half_track   <= cfg_i.data;
        CFG_STEP:   cfg_q.time_step    <= cfg_i.data;
        CFG_LIMIT:  cfg_q.wheel_limit  <= cfg_i.data[14:0];
        CFG_READY:  cfg_q.wheels_ready <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  ddpi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ddpi_datapath #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_i           (cfg_q),
    .left_speed_i    (in_i.left_speed),
    .right_speed_i   (in_i.right_speed),
    .pos_x_o         (out_o.pos_x),
    .pos_y_o         (out_o.pos_y),
    .heading_angle_o (out_o.heading_angle),
    .was_limited_o   (out_o.was_limited),
    .not_ready_o     (out_o.not_ready)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("transfer taken while an item is in work");

  a_held_not_limited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) && out_o.not_ready |-> !out_o.was_limited)
    else $error("held pose flagged as limited");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> !$past(in_i.ready))
    else $error("result appeared straight from idle");

endmodule
